>>> rtl/multi_waveform_oscillator_core_macros.svh
// assertion macros for the oscillator core
`ifndef MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH
`define MULTI_WAVEFORM_OSCILLATOR_CORE_MACROS_SVH

// same-cycle implication, checked on clk_i outside reset
`define MWO_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("oscillator core check failed");

// next-cycle implication, checked on clk_i outside reset
`define MWO_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("oscillator core check failed");

`endif

>>> rtl/mwo_pkg.sv
// shared types, constants and sine table for the oscillator core
`default_nettype none

package mwo_pkg;

  localparam int unsigned SINE_TABLE_DEPTH = 1024;
  localparam int unsigned PHASE_BITS = 32;
  localparam int unsigned SAMPLE_BITS = 16;
  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned AMP_BITS = 15;
  localparam int unsigned COUNT_REG_BITS = 25;
  localparam int unsigned CFG_DATA_BITS = 32;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned COUNT_BITS = INDEX_BITS + 1;

  localparam int unsigned TAB_LOG2 = $clog2(SINE_TABLE_DEPTH + 1) - 1;
  localparam int unsigned TAB_SPAN = 1 << TAB_LOG2;
  localparam int unsigned POS_BITS = TAB_LOG2 + 1;
  localparam int unsigned MAG_BITS = SAMPLE_BITS - 1;
  localparam int unsigned SAMPLE_MAX = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int unsigned SAMPLE_MID = 1 << (SAMPLE_BITS - 1);
  localparam int unsigned ROUND_HALF = 1 << (AMP_BITS - 1);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // taylor series divisors, innermost term first
  localparam longint unsigned TAYLOR_DIV_11 = 64'd110;
  localparam longint unsigned TAYLOR_DIV_9 = 64'd72;
  localparam longint unsigned TAYLOR_DIV_7 = 64'd42;
  localparam longint unsigned TAYLOR_DIV_5 = 64'd20;
  localparam longint unsigned TAYLOR_DIV_3 = 64'd6;

  typedef enum logic [1:0] {
    WAVE_SINE   = 2'd0,
    WAVE_SQUARE = 2'd1,
    WAVE_SAW    = 2'd2,
    WAVE_SILENT = 2'd3
  } wave_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_WAVEFORM     = 3'd0,
    REG_PHASE_STEP   = 3'd1,
    REG_PHASE_OFFSET = 3'd2,
    REG_AMPLITUDE    = 3'd3,
    REG_SAMPLE_COUNT = 3'd4
  } cfg_reg_e;

  // one classified request between front and back
  typedef struct packed {
    logic                   use_tab;
    logic [POS_BITS-1:0]    pos;
    logic [SAMPLE_BITS-1:0] mag;
    logic                   neg;
    logic [INDEX_BITS-1:0]  idx;
    logic                   last;
  } mwo_req_t;

  typedef logic [MAG_BITS-1:0] sine_mag_t;
  typedef sine_mag_t sine_rom_t [TAB_SPAN+1];

  // quarter-wave sine entry, taylor series to x^11 in q30
  function automatic sine_mag_t sine_entry(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    longint unsigned v;
    x = (HALF_PI_Q30 * k) >> TAB_LOG2;
    x2 = (x * x) >> 30;
    t = Q30_ONE;
    t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV_11);
    t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV_9);
    t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV_7);
    t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV_5);
    t = Q30_ONE - (((x2 * t) >> 30) / TAYLOR_DIV_3);
    s = (x * t) >> 30;
    v = (s * SAMPLE_MAX + (Q30_ONE >> 1)) >> 30;
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end
    return v[MAG_BITS-1:0];
  endfunction

  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    for (int k = 0; k <= TAB_SPAN; k++) begin
      rom[k] = sine_entry(longint'(k));
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> rtl/mwo_front.sv
// front end: takes ticks, steps the phase and classifies each sample
`default_nettype none

module mwo_front
  import mwo_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic                  restart_i,
  input  wire wave_e                 waveform_i,
  input  wire logic [PHASE_BITS-1:0] phase_step_i,
  input  wire logic [PHASE_BITS-1:0] phase_offset_i,
  input  wire logic [COUNT_BITS-1:0] count_i,
  input  wire logic                  q_full_i,
  output logic                       push_o,
  output mwo_req_t                   req_o
);

  logic [INDEX_BITS-1:0]  run_index_q, run_index_d;
  logic [PHASE_BITS-1:0]  phase_accum_q, phase_accum_d;
  logic [INDEX_BITS-1:0]  ri;
  logic [PHASE_BITS-1:0]  pa;
  logic [PHASE_BITS-1:0]  phase;
  logic [SAMPLE_BITS-1:0] top;
  logic [COUNT_BITS-1:0]  next_cnt;
  logic                   last;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    ri       = restart_i ? '0 : run_index_q;
    pa       = restart_i ? '0 : phase_accum_q;
    phase    = phase_offset_i + pa;
    next_cnt = {1'b0, ri} + COUNT_BITS'(1);
    last     = next_cnt >= count_i;
    top      = phase[PHASE_BITS-1 -: SAMPLE_BITS];

    req_o      = '0;
    req_o.idx  = ri;
    req_o.last = last;
    case (waveform_i)
      WAVE_SINE: begin
        req_o.use_tab = 1'b1;
        req_o.pos     = {1'b0, phase[PHASE_BITS-3 -: TAB_LOG2]};
        if (phase[PHASE_BITS-2]) begin
          req_o.pos = POS_BITS'(TAB_SPAN) - req_o.pos;
        end
        req_o.neg = phase[PHASE_BITS-1];
      end
      WAVE_SQUARE: begin
        req_o.mag = SAMPLE_BITS'(SAMPLE_MAX);
        req_o.neg = !((phase != '0) && !phase[PHASE_BITS-1]);
      end
      WAVE_SAW: begin
        if (top[SAMPLE_BITS-1]) begin
          req_o.mag = {1'b0, top[SAMPLE_BITS-2:0]};
        end else begin
          req_o.mag = SAMPLE_BITS'(SAMPLE_MID) - top;
          req_o.neg = 1'b1;
        end
      end
      default: begin
        req_o.mag = '0;
      end
    endcase

    run_index_d   = run_index_q;
    phase_accum_d = phase_accum_q;
    if (push_o) begin
      if (last) begin
        run_index_d   = '0;
        phase_accum_d = '0;
      end else begin
        run_index_d   = ri + INDEX_BITS'(1);
        phase_accum_d = pa + phase_step_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_index_q   <= '0;
      phase_accum_q <= '0;
    end else begin
      run_index_q   <= run_index_d;
      phase_accum_q <= phase_accum_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mwo_queue.sv
// short request queue between front and back
`default_nettype none

module mwo_queue
  import mwo_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire mwo_req_t req_i,
  output logic          full_o,
  input  wire logic     pop_i,
  output logic          valid_o,
  output mwo_req_t      req_o
);

  mwo_req_t               slot_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_BITS-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_BITS-1:0]   cnt_q, cnt_d;

  assign full_o  = cnt_q == QCNT_BITS'(QUEUE_DEPTH);
  assign valid_o = cnt_q != '0;
  assign req_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_BITS'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_BITS'(1);
    end
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + QCNT_BITS'(1);
      2'b01:   cnt_d = cnt_q - QCNT_BITS'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= req_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/mwo_back.sv
// back end: table lookup, amplitude scaling and output register
`default_nettype none

module mwo_back
  import mwo_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   q_valid_i,
  input  wire mwo_req_t               q_req_i,
  output logic                        q_pop_o,
  input  wire logic [AMP_BITS-1:0]    amplitude_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic [INDEX_BITS-1:0]       sample_index_o,
  output logic                        last_of_run_o
);

  localparam int unsigned PROD_BITS = AMP_BITS + SAMPLE_BITS;
  localparam int unsigned SUM_BITS = PROD_BITS + 1;

  logic                   a_valid_q;
  mwo_req_t               a_req_q;
  sine_mag_t              a_rom_q;
  logic                   out_valid_q;
  logic [SAMPLE_BITS-1:0] sample_q, sample_d;
  logic [INDEX_BITS-1:0]  idx_q;
  logic                   last_q;
  logic                   out_adv;
  logic                   a_adv;
  logic [SAMPLE_BITS-1:0] mag;
  logic [PROD_BITS-1:0]   prod;
  logic [SUM_BITS-1:0]    sum;
  logic [SAMPLE_BITS-1:0] scaled;

  assign out_adv = !out_valid_q || out_ready_i;
  assign a_adv   = !a_valid_q || out_adv;
  assign q_pop_o = q_valid_i && a_adv;

  always_comb begin
    mag      = a_req_q.use_tab ? {1'b0, a_rom_q} : a_req_q.mag;
    prod     = PROD_BITS'(amplitude_i) * PROD_BITS'(mag);
    sum      = {1'b0, prod} + SUM_BITS'(ROUND_HALF);
    scaled   = sum[AMP_BITS +: SAMPLE_BITS];
    sample_d = a_req_q.neg ? (SAMPLE_BITS'(0) - scaled) : scaled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_adv) begin
        a_valid_q <= q_valid_i;
      end
      if (out_adv) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      a_req_q <= q_req_i;
      a_rom_q <= SINE_ROM[q_req_i.pos];
    end
    if (out_adv && a_valid_q) begin
      sample_q <= sample_d;
      idx_q    <= a_req_q.idx;
      last_q   <= a_req_q.last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = $signed(sample_q);
  assign sample_index_o = idx_q;
  assign last_of_run_o  = last_q;

endmodule

`default_nettype wire

>>> rtl/multi_waveform_oscillator_core.sv
// top level of the multi-waveform dds oscillator core
//
//  channel   handshake                payload
//  -------   ---------                -------
//  tick in   in_valid_i / in_ready_o  restart_i
//  sample    out_valid_o / out_ready_i sample_o, sample_index_o, last_of_run_o
//  config    cfg_we_i (no wait)       cfg_idx_i, cfg_wdata_i
//
// one tick in and one sample out per cycle when neither side stalls
// a tick is registered in its queue slot, then in the rom stage, then in the output register
// the front steps the phase accumulator on accept; the back reads the rom and multiplies
// a two-entry queue lets the front keep taking ticks while the output is held
// reset clears run index, phase and queue; config registers take their defaults
`default_nettype none
`include "multi_waveform_oscillator_core_macros.svh"

module multi_waveform_oscillator_core
  import mwo_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     restart_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] sample_o,
  output logic [INDEX_BITS-1:0]         sample_index_o,
  output logic                          last_of_run_o
);

  // configuration registers
  wave_e                     waveform_q;
  logic [PHASE_BITS-1:0]     phase_step_q;
  logic [PHASE_BITS-1:0]     phase_offset_q;
  logic [AMP_BITS-1:0]       amplitude_q;
  logic [COUNT_REG_BITS-1:0] sample_count_q;

  // run length clamped to [1, 2^INDEX_BITS]
  logic [COUNT_BITS-1:0]     count_sat;

  // front to queue, queue to back
  logic     push;
  mwo_req_t front_req;
  logic     q_full;
  logic     q_valid;
  mwo_req_t q_req;
  logic     q_pop;

  // helpers for the checks below
  logic [COUNT_BITS-1:0]         out_next_cnt;
  logic signed [SAMPLE_BITS-1:0] amp_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waveform_q     <= WAVE_SINE;
      phase_step_q   <= PHASE_BITS'(42852282);
      phase_offset_q <= '0;
      amplitude_q    <= AMP_BITS'(16384);
      sample_count_q <= COUNT_REG_BITS'(44100);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_WAVEFORM:     waveform_q     <= wave_e'(cfg_wdata_i[1:0]);
        REG_PHASE_STEP:   phase_step_q   <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_PHASE_OFFSET: phase_offset_q <= cfg_wdata_i[PHASE_BITS-1:0];
        REG_AMPLITUDE:    amplitude_q    <= cfg_wdata_i[AMP_BITS-1:0];
        REG_SAMPLE_COUNT: sample_count_q <= cfg_wdata_i[COUNT_REG_BITS-1:0];
        default: ;
      endcase
    end
  end

  // zero count acts as one, oversize count saturates to the index span
  always_comb begin
    if (sample_count_q == '0) begin
      count_sat = COUNT_BITS'(1);
    end else if (COUNT_BITS'(sample_count_q) > (COUNT_BITS'(1) << INDEX_BITS)) begin
      count_sat = COUNT_BITS'(1) << INDEX_BITS;
    end else begin
      count_sat = COUNT_BITS'(sample_count_q);
    end
  end

  // phase stepping and waveform classification
  mwo_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .waveform_i     (waveform_q),
    .phase_step_i   (phase_step_q),
    .phase_offset_i (phase_offset_q),
    .count_i        (count_sat),
    .q_full_i       (q_full),
    .push_o         (push),
    .req_o          (front_req)
  );

  // decouples front acceptance from output stalls
  mwo_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .req_i   (front_req),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .req_o   (q_req)
  );

  // sine rom, amplitude multiply with rounding, output register
  mwo_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_req_i        (q_req),
    .q_pop_o        (q_pop),
    .amplitude_i    (amplitude_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sample_o       (sample_o),
    .sample_index_o (sample_index_o),
    .last_of_run_o  (last_of_run_o)
  );

  assign out_next_cnt = {1'b0, sample_index_o} + COUNT_BITS'(1);
  assign amp_s        = $signed({1'b0, amplitude_q});

  // a sample not flagged last must leave room in the run
  `MWO_ASSERT_IMPLY(a_not_last_in_run, out_valid_o && !last_of_run_o, out_next_cnt < count_sat)

  // scaled output never exceeds the programmed amplitude
  `MWO_ASSERT_IMPLY(a_sample_bounded, out_valid_o, (sample_o <= amp_s) && (sample_o >= -amp_s))

  // silent mode gives zero samples
  `MWO_ASSERT_IMPLY(a_silent_zero, out_valid_o && (waveform_q == WAVE_SILENT), sample_o == '0)

  // a full queue holds off new ticks in the following cycle unless a request leaves
  `MWO_ASSERT_NEXT(a_full_blocks, q_full && !q_pop, !in_ready_o)

endmodule

`default_nettype wire

>>> tb/oscillator_sample_checker.sv
// scoreboard for the oscillator core: mirrors the registers, predicts each sample and compares
module oscillator_sample_checker
  import mwo_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     restart_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [SAMPLE_BITS-1:0]   sample_i,
  input  logic [INDEX_BITS-1:0]    sample_index_i,
  input  logic                     last_of_run_i,
  output int unsigned              fail_count_o,
  output int unsigned              pending_o
);

  localparam logic [PHASE_BITS-1:0] STEP_AT_RESET = 32'd42852282;
  localparam logic [AMP_BITS-1:0] AMP_AT_RESET = 15'd16384;
  localparam logic [COUNT_REG_BITS-1:0] COUNT_AT_RESET = 25'd44100;
  localparam longint unsigned Q30 = 64'd1 << 30;
  localparam longint unsigned HALF_PI_FIX = 64'd1686629713;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample;
    logic [INDEX_BITS-1:0]  index;
    logic                   last;
  } sample_rec_t;

  wave_e                     cfg_wave;
  logic [PHASE_BITS-1:0]     cfg_step;
  logic [PHASE_BITS-1:0]     cfg_offset;
  logic [AMP_BITS-1:0]       cfg_amp;
  logic [COUNT_REG_BITS-1:0] cfg_count;
  logic [INDEX_BITS-1:0]     run_index;
  logic [PHASE_BITS-1:0]     phase_acc;
  sample_rec_t               expected_samples[$];
  sample_rec_t               oldest;
  int unsigned               mismatches;

  assign fail_count_o = mismatches;

  // quarter-wave sine magnitude at table position k, taylor series to x^11 in q30
  function automatic longint unsigned quarter_sine(input longint unsigned k);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned series;
    longint unsigned divisor;
    longint unsigned s;
    longint unsigned v;
    x = (HALF_PI_FIX * k) / TAB_SPAN;
    x2 = (x * x) >> 30;
    series = Q30;
    for (int n = 0; n < 5; n++) begin
      divisor = (11 - 2 * n) * (10 - 2 * n);
      series = Q30 - ((x2 * series) >> 30) / divisor;
    end
    s = (x * series) >> 30;
    v = (s * SAMPLE_MAX + (Q30 >> 1)) >> 30;
    if (v > SAMPLE_MAX) begin
      v = SAMPLE_MAX;
    end
    return v;
  endfunction

  // one tick: returns the sample it yields and advances index and phase
  function automatic sample_rec_t step_oscillator(input logic restart);
    logic [PHASE_BITS-1:0]  phase;
    logic [1:0]             quad;
    logic [TAB_LOG2:0]      pos;
    logic [SAMPLE_BITS-1:0] top;
    longint unsigned        mag;
    longint unsigned        scaled;
    longint unsigned        word;
    longint unsigned        run_len;
    logic                   neg;
    sample_rec_t            rec;
    if (restart) begin
      run_index = '0;
      phase_acc = '0;
    end
    phase = cfg_offset + phase_acc;
    mag = 0;
    neg = 1'b0;
    case (cfg_wave)
      WAVE_SINE: begin
        quad = phase[PHASE_BITS-1 -: 2];
        pos = {1'b0, phase[PHASE_BITS-3 -: TAB_LOG2]};
        if (quad[0]) begin
          pos = (TAB_LOG2 + 1)'(TAB_SPAN - pos);
        end
        mag = quarter_sine(longint'(pos));
        neg = quad[1];
      end
      WAVE_SQUARE: begin
        mag = SAMPLE_MAX;
        neg = !(phase != '0 && !phase[PHASE_BITS-1]);
      end
      WAVE_SAW: begin
        top = phase[PHASE_BITS-1 -: SAMPLE_BITS];
        neg = !top[SAMPLE_BITS-1];
        mag = neg ? (SAMPLE_MID - top) : (top - SAMPLE_MID);
      end
      default: begin
      end
    endcase
    scaled = (longint'(cfg_amp) * mag + ROUND_HALF) >> AMP_BITS;
    word = neg ? (64'd0 - scaled) : scaled;
    // zero count behaves as one, counts past the index range saturate
    run_len = longint'(cfg_count);
    if (run_len == 0) begin
      run_len = 1;
    end
    if (run_len > (64'd1 << INDEX_BITS)) begin
      run_len = 64'd1 << INDEX_BITS;
    end
    rec.sample = word[SAMPLE_BITS-1:0];
    rec.index = run_index;
    rec.last = (longint'(run_index) + 1) >= run_len;
    if (rec.last) begin
      run_index = '0;
      phase_acc = '0;
    end else begin
      run_index = run_index + 1'b1;
      phase_acc = phase_acc + cfg_step;
    end
    return rec;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_wave = WAVE_SINE;
      cfg_step = STEP_AT_RESET;
      cfg_offset = '0;
      cfg_amp = AMP_AT_RESET;
      cfg_count = COUNT_AT_RESET;
      run_index = '0;
      phase_acc = '0;
      expected_samples.delete();
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_WAVEFORM:     cfg_wave = wave_e'(cfg_wdata_i[1:0]);
          REG_PHASE_STEP:   cfg_step = cfg_wdata_i[PHASE_BITS-1:0];
          REG_PHASE_OFFSET: cfg_offset = cfg_wdata_i[PHASE_BITS-1:0];
          REG_AMPLITUDE:    cfg_amp = cfg_wdata_i[AMP_BITS-1:0];
          REG_SAMPLE_COUNT: cfg_count = cfg_wdata_i[COUNT_REG_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        expected_samples.push_back(step_oscillator(restart_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_samples.size() == 0) begin
          $error("unexpected sample %0d at index %0d", $signed(sample_i), sample_index_i);
          mismatches = mismatches + 1;
        end else begin
          oldest = expected_samples.pop_front();
          if (sample_i !== oldest.sample) begin
            $error("sample_o: expected %0d, got %0d", $signed(oldest.sample), $signed(sample_i));
            mismatches = mismatches + 1;
          end
          if (sample_index_i !== oldest.index) begin
            $error("sample_index_o: expected %0d, got %0d", oldest.index, sample_index_i);
            mismatches = mismatches + 1;
          end
          if (last_of_run_i !== oldest.last) begin
            $error("last_of_run_o: expected %0b, got %0b", oldest.last, last_of_run_i);
            mismatches = mismatches + 1;
          end
        end
      end
      pending_o <= expected_samples.size();
    end
  end

endmodule

>>> tb/tb_multi_waveform_oscillator_core.sv
// top of the oscillator core testbench: clock, reset, stimulus, watchdog and verdict
module tb_multi_waveform_oscillator_core;
  import mwo_pkg::*;

  localparam int TOTAL_TICKS = 1050;
  // no stalls on either side while the ticks from CALM_START to CALM_END go through
  localparam int CALM_START = 450;
  localparam int CALM_END = 650;
  localparam int STALL_PERCENT = 36;
  localparam int RESTART_PERCENT = 6;
  localparam int WATCHDOG_LIMIT = 5000;
  // idle time after the final drain before the verdict
  localparam int SETTLE_CYCLES = 12;
  localparam logic [CFG_DATA_BITS-1:0] AMP_MAX = CFG_DATA_BITS'((64'd1 << AMP_BITS) - 1);
  localparam logic [CFG_DATA_BITS-1:0] COUNT_REG_MAX =
    CFG_DATA_BITS'((64'd1 << COUNT_REG_BITS) - 1);
  localparam logic [CFG_DATA_BITS-1:0] INDEX_SPAN = CFG_DATA_BITS'(64'd1 << INDEX_BITS);
  localparam logic [CFG_IDX_BITS-1:0] SPARE_REG = '1;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic                     restart_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic [SAMPLE_BITS-1:0]   sample_o;
  logic [INDEX_BITS-1:0]    sample_index_o;
  logic                     last_of_run_o;

  int unsigned mismatch_total;
  int unsigned samples_owed;
  int          ticks_sent = 0;
  int          quiet_cycles = 0;
  // random idle cycles on the tick side and stalls on the sample side
  logic        source_gaps = 1'b1;
  logic        sink_stalls = 1'b1;

  multi_waveform_oscillator_core dut (.*);

  oscillator_sample_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .restart_i     (restart_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .sample_i      (sample_o),
    .sample_index_i(sample_index_o),
    .last_of_run_i (last_of_run_o),
    .fail_count_o  (mismatch_total),
    .pending_o     (samples_owed)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sample side: ready drops at random while stalls are enabled
  always @(posedge clk_i) begin
    out_ready_i <= !(sink_stalls && $urandom_range(99) < STALL_PERCENT);
  end

  // watchdog: any transfer on any channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // one tick request, with random idle cycles ahead of it; valid stays up on return
  task automatic send_tick(input logic restart);
    while (source_gaps && $urandom_range(99) < STALL_PERCENT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    restart_i <= restart;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  // stop sending and wait until every expected sample has come out
  // the first edge lets the owed count take in a tick accepted this cycle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (samples_owed != 0) begin
      @(posedge clk_i);
    end
  endtask

  // one register write; the caller drops the write enable after its last write
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  // sometimes sets the bits above a register's width; the core drops them
  function automatic logic [CFG_DATA_BITS-1:0] with_junk(input logic [CFG_DATA_BITS-1:0] value,
                                                         input int width);
    logic [CFG_DATA_BITS-1:0] keep;
    keep = CFG_DATA_BITS'((64'd1 << width) - 1);
    if ($urandom_range(3) == 0) begin
      return (value & keep) | ($urandom & ~keep);
    end
    return value & keep;
  endfunction

  // directed phase: full register set, then n ticks with a restart on the first
  task automatic run_directed(input wave_e wave, input logic [CFG_DATA_BITS-1:0] step,
                              input logic [CFG_DATA_BITS-1:0] offset,
                              input logic [CFG_DATA_BITS-1:0] amp,
                              input logic [CFG_DATA_BITS-1:0] count, input int n);
    wait_drained();
    write_reg(REG_WAVEFORM, CFG_DATA_BITS'(wave));
    write_reg(REG_PHASE_STEP, step);
    write_reg(REG_PHASE_OFFSET, offset);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_SAMPLE_COUNT, count);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < n; i++) begin
      send_tick(i == 0);
    end
    ticks_sent += n;
  endtask

  // rewrite a random subset of the registers, extremes included
  task automatic shuffle_settings();
    logic [CFG_DATA_BITS-1:0] value;
    if ($urandom_range(1)) begin
      write_reg(REG_WAVEFORM, with_junk($urandom_range(WAVE_SILENT), 2));
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(7))
        0:       value = '0;
        1:       value = 32'h8000_0000;
        2:       value = '1;
        3:       value = $urandom_range(1, 1 << 20);
        default: value = $urandom;
      endcase
      write_reg(REG_PHASE_STEP, value);
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0:       value = '0;
        // exactly on a quadrant boundary
        1:       value = $urandom_range(3) << (PHASE_BITS - 2);
        default: value = $urandom;
      endcase
      write_reg(REG_PHASE_OFFSET, value);
    end
    if ($urandom_range(1)) begin
      case ($urandom_range(5))
        0:       value = '0;
        1:       value = AMP_MAX;
        default: value = $urandom_range(AMP_MAX);
      endcase
      write_reg(REG_AMPLITUDE, with_junk(value, AMP_BITS));
    end
    if ($urandom_range(1)) begin
      // mostly short runs so that wraps and last flags come often
      case ($urandom_range(11))
        0:       value = '0;
        1:       value = INDEX_SPAN;
        2:       value = $urandom_range(INDEX_SPAN + 1, COUNT_REG_MAX);
        3:       value = $urandom_range(49, INDEX_SPAN - 1);
        default: value = $urandom_range(1, 48);
      endcase
      write_reg(REG_SAMPLE_COUNT, with_junk(value, COUNT_REG_BITS));
    end
    // a write to an unused index must change nothing
    if ($urandom_range(7) == 0) begin
      write_reg(CFG_IDX_BITS'($urandom_range(REG_SAMPLE_COUNT + 1, SPARE_REG)), $urandom);
    end
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int burst;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: sine at the default step
    send_tick(1'b1);
    send_tick(1'b0);
    ticks_sent += 2;
    // sine on the four quadrant boundaries, mirrored table end included, then wrap
    run_directed(WAVE_SINE, 32'h4000_0000, '0, AMP_MAX, 5, 5);
    // square at phase one, zero and the top phase
    run_directed(WAVE_SQUARE, 32'hffff_ffff, 32'd1, AMP_MAX, 3, 3);
    // sawtooth at mid, bottom, just below mid and full; count above the index range
    run_directed(WAVE_SAW, 32'h7fff_ffff, 32'h8000_0001, AMP_MAX, COUNT_REG_MAX, 4);
    // silent mode still walks the index up to the last flag
    run_directed(WAVE_SILENT, '0, '0, AMP_MAX, 3, 3);
    // zero count: every sample ends its run
    run_directed(WAVE_SQUARE, 32'h1234_5678, 32'h0000_0100, 32'd1, '0, 2);
    // zero amplitude, then the count dropped below the current index mid-run
    run_directed(WAVE_SINE, 32'h0100_0000, 32'h3ff0_0000, '0, 1000, 3);
    wait_drained();
    write_reg(REG_SAMPLE_COUNT, 32'd2);
    cfg_we_i <= 1'b0;
    send_tick(1'b0);
    ticks_sent++;

    // random phases; each one drains the core before touching the registers
    while (ticks_sent < TOTAL_TICKS) begin
      wait_drained();
      shuffle_settings();
      burst = $urandom_range(4, 60);
      for (int i = 0; i < burst && ticks_sent < TOTAL_TICKS; i++) begin
        if (ticks_sent == CALM_START) begin
          source_gaps <= 1'b0;
          sink_stalls <= 1'b0;
        end else if (ticks_sent == CALM_END) begin
          source_gaps <= 1'b1;
          sink_stalls <= 1'b1;
        end
        send_tick($urandom_range(99) < RESTART_PERCENT);
        ticks_sent++;
        // occasional drain in mid-phase with the settings left alone
        if ($urandom_range(63) == 0) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
